[rtl/core/tcit_pkg.sv]
// Shared types, codes and helper functions for the three-channel interval timer.
// Used by the counter slice and the top level; depends on nothing else.
`timescale 1ns / 1ps

package tcit_pkg;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_GATE  = 2'd3
    } action_t;

    localparam logic [1:0]  MODE_PORT     = 2'd3;
    localparam logic [1:0]  ACC_LOW_ONLY  = 2'd1;
    localparam logic [1:0]  ACC_HIGH_ONLY = 2'd2;
    localparam logic [7:0]  MODE_PORT_RD  = 8'hFF;
    localparam logic [15:0] BCD_TOP_MASK  = 16'hF000;
    localparam logic [15:0] BCD_TOP_CLEAR = 16'h9FFF;

    // Decoded request for one counter slice.
    typedef struct packed {
        logic       fire;
        logic       wr_load;
        logic       wr_mode;
        logic       rd;
        logic       tick;
        logic       gate;
        logic [7:0] data;
    } cnt_cmd_t;

    // What one counter slice reports for the current item.
    typedef struct packed {
        logic       ev;
        logic       level;
        logic [7:0] rd_byte;
    } cnt_res_t;

    // After a decrement, the first nibble from the top that reads all ones is forced to 9.
    function automatic logic [15:0] bcd_fix(input logic [15:0] v);
        logic [15:0] r;
        if ((v & BCD_TOP_MASK) == BCD_TOP_MASK)
            r = v & BCD_TOP_CLEAR;
        else if (v[11:8] == 4'hF)
            r = v & 16'hF9FF;
        else if (v[7:4] == 4'hF)
            r = v & 16'hFF9F;
        else if (v[3:0] == 4'hF)
            r = v & 16'hFFF9;
        else
            r = v;
        return r;
    endfunction

endpackage

[rtl/core/tcit_counter.sv]
// One counter slice of the interval timer: reload, count, mode and byte toggles.
// Depends on tcit_pkg for the command and result structs and the BCD fix-up.
`timescale 1ns / 1ps

module tcit_counter
    import tcit_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cnt_cmd_t cmd,
    output cnt_res_t res
);

    logic [15:0] reload_reg, reload_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  mode_reg, mode_next;
    logic        rtog_reg, rtog_next;
    logic        wtog_reg, wtog_next;
    logic        run_reg, run_next;

    logic [2:0]  mode_num;
    logic [1:0]  acc;
    logic        acc_pair;
    logic        high_sel;
    logic        done;
    logic [15:0] new_reload;
    logic [15:0] dec;
    logic [15:0] tick_val;

    assign mode_num = mode_reg[3:1];
    assign acc      = mode_reg[5:4];
    assign acc_pair = (acc != ACC_LOW_ONLY) && (acc != ACC_HIGH_ONLY);
    assign high_sel = (acc == ACC_HIGH_ONLY) || (acc_pair && wtog_reg);
    assign done     = !acc_pair || wtog_reg;
    assign dec      = count_reg - 16'd1;
    assign tick_val = mode_reg[0] ? bcd_fix(dec) : dec;

    always_comb
    begin
        new_reload = high_sel ? {cmd.data, reload_reg[7:0]} : {reload_reg[15:8], cmd.data};
    end

    always_comb
    begin
        reload_next = reload_reg;
        count_next  = count_reg;
        mode_next   = mode_reg;
        rtog_next   = rtog_reg;
        wtog_next   = wtog_reg;
        run_next    = run_reg;
        res         = '0;

        if (cmd.wr_load)
        begin
            reload_next = new_reload;
            count_next  = new_reload;
            wtog_next   = acc_pair ? !wtog_reg : 1'b0;
            if (done)
            begin
                if (mode_num != 3'd1 && mode_num != 3'd5)
                    run_next = 1'b1;
                if (mode_num == 3'd0)
                    res.ev = 1'b1;
            end
        end
        if (cmd.wr_mode)
            mode_next = cmd.data;
        if (cmd.rd)
        begin
            if (acc == ACC_LOW_ONLY)
            begin
                rtog_next   = 1'b0;
                res.rd_byte = count_reg[7:0];
            end
            else if (acc == ACC_HIGH_ONLY)
            begin
                rtog_next   = 1'b0;
                res.rd_byte = count_reg[15:8];
            end
            else
            begin
                rtog_next   = !rtog_reg;
                res.rd_byte = rtog_reg ? count_reg[15:8] : count_reg[7:0];
            end
        end
        if (cmd.tick && run_reg)
        begin
            if (tick_val == 16'd0)
            begin
                res.ev     = 1'b1;
                count_next = reload_reg;
                if (mode_num == 3'd0 || mode_num == 3'd1)
                    run_next = 1'b0;
            end
            else
            begin
                count_next = tick_val;
                if (tick_val == 16'd1)
                begin
                    if (mode_num == 3'd2 || mode_num == 3'd6)
                        res.ev = 1'b1;
                end
                else if ((mode_num == 3'd3 || mode_num == 3'd7)
                         && tick_val == {1'b0, reload_reg[15:1]})
                begin
                    res.ev = 1'b1;
                end
                else if ((mode_num == 3'd4 || mode_num == 3'd5)
                         && tick_val == reload_reg - 16'd1)
                begin
                    res.ev    = 1'b1;
                    res.level = 1'b1;
                end
            end
        end
        if (cmd.gate)
        begin
            if (mode_num == 3'd0 || mode_num == 3'd1 || mode_num == 3'd4 || mode_num == 3'd5)
                run_next = (cmd.data != 8'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg <= '0;
            count_reg  <= '0;
            mode_reg   <= '0;
            rtog_reg   <= 1'b0;
            wtog_reg   <= 1'b0;
            run_reg    <= 1'b0;
        end
        else if (cmd.fire)
        begin
            reload_reg <= reload_next;
            count_reg  <= count_next;
            mode_reg   <= mode_next;
            rtog_reg   <= rtog_next;
            wtog_reg   <= wtog_next;
            run_reg    <= run_next;
        end
    end

endmodule

[rtl/core/three_channel_interval_timer.sv]
// Top level of the three-channel interval timer: input register, counter slices, result register.
// Depends on tcit_pkg and tcit_counter.
`timescale 1ns / 1ps
//
// Usage:
// The input channel (in_valid, in_stall, action, port, data) carries one action per transfer:
// a port write, a port read, a clock tick or a gate level change. The output channel
// (out_valid, out_stall, read_data, event_mask, event_levels, error) returns exactly one
// result transfer per input transfer, in order.
// An accepted item waits in the input register, where the counter slices evaluate it and
// update their state; its result is registered in the output register at the same edge
// as that update, and out_valid rises with it. A stall on the output holds the item in
// the input register.
// Throughput is one item per cycle: the per-counter decrement, BCD fix-up and compares sit
// between the input register and the output register, and the input register is free again
// whenever the output register is empty or being taken.
// When the receiver holds out_stall, the result stays in place; one more item may wait in
// the input register, and in_stall rises only when both registers are full.
// Reset clears all counters, reload values, mode bytes, toggles and both valid flags.
//

module three_channel_interval_timer
    import tcit_pkg::*;
#(
    parameter int NUM_COUNTERS = 3
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] action,
    input  logic [1:0] port,
    input  logic [7:0] data,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_data,
    output logic [2:0] event_mask,
    output logic [2:0] event_levels,
    output logic       error
);

    localparam logic [2:0] NC = 3'(NUM_COUNTERS);

    logic       s1_valid_reg, s1_valid_next;
    action_t    s1_action_reg;
    logic [1:0] s1_port_reg;
    logic [7:0] s1_data_reg;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] rd_reg, rd_next;
    logic [2:0] mask_reg, mask_next;
    logic [2:0] lvl_reg, lvl_next;
    logic       err_reg, err_next;

    logic       adv;
    logic       take;
    logic       fire;
    logic [1:0] mode_sel;

    cnt_cmd_t   cmd [3];
    cnt_res_t   res [3];

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !adv;
    assign take     = in_valid && !in_stall;
    assign fire     = s1_valid_reg && adv;
    assign mode_sel = s1_data_reg[7:6];

    genvar c;
    generate
        for (c = 0; c < 3; c++)
        begin : g_cnt
            if (c < NUM_COUNTERS)
            begin : g_on
                always_comb
                begin
                    cmd[c].fire    = fire;
                    cmd[c].wr_load = (s1_action_reg == ACT_WRITE) && (s1_port_reg == 2'(c));
                    cmd[c].wr_mode = (s1_action_reg == ACT_WRITE) && (s1_port_reg == MODE_PORT)
                                     && (mode_sel == 2'(c));
                    cmd[c].rd      = (s1_action_reg == ACT_READ) && (s1_port_reg == 2'(c));
                    cmd[c].tick    = (s1_action_reg == ACT_TICK);
                    cmd[c].gate    = (s1_action_reg == ACT_GATE) && (s1_port_reg == 2'(c));
                    cmd[c].data    = s1_data_reg;
                end

                tcit_counter u_cnt (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .cmd   (cmd[c]),
                    .res   (res[c])
                );
            end
            else
            begin : g_off
                assign cmd[c] = '0;
                assign res[c] = '0;
            end
        end
    endgenerate

    always_comb
    begin
        rd_next   = 8'd0;
        mask_next = {res[2].ev, res[1].ev, res[0].ev};
        lvl_next  = {res[2].level, res[1].level, res[0].level} & mask_next;
        err_next  = 1'b0;
        case (s1_action_reg)
            ACT_WRITE:
            begin
                if (s1_port_reg == MODE_PORT)
                    err_next = ({1'b0, mode_sel} >= NC);
            end
            ACT_READ:
            begin
                if (s1_port_reg == MODE_PORT)
                    rd_next = MODE_PORT_RD;
                else
                    rd_next = res[0].rd_byte | res[1].rd_byte | res[2].rd_byte;
            end
            ACT_GATE:
            begin
                err_next = ({1'b0, s1_port_reg} >= NC);
            end
            default:
            begin
                err_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (take)
            s1_valid_next = 1'b1;
        else if (fire)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
        out_valid_next = adv ? fire : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_action_reg <= action_t'(action);
            s1_port_reg   <= port;
            s1_data_reg   <= data;
        end
        if (fire)
        begin
            rd_reg   <= rd_next;
            mask_reg <= mask_next;
            lvl_reg  <= lvl_next;
            err_reg  <= err_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = rd_reg;
    assign event_mask   = mask_reg;
    assign event_levels = lvl_reg;
    assign error        = err_reg;

endmodule

[rtl/core/tcit_checker.sv]
// Port-level checks for the interval timer's result channel, bound to the top level.
// Depends only on the top level's port names.
`timescale 1ns / 1ps

module tcit_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] read_data,
    input logic [2:0] event_mask,
    input logic [2:0] event_levels,
    input logic       error
);

    // A level is only reported for a counter that actually drove its output.
    a_levels_in_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((event_levels & ~event_mask) == 3'd0))
        else $error("event level set outside the event mask");

    // Rejected mode words and gates change nothing, so they carry no events and no read byte.
    a_error_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error) |-> (event_mask == 3'd0 && read_data == 8'd0))
        else $error("error result carries events or read data");

    // Only reads return data, and reads never move a counter output.
    a_read_no_event: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && read_data != 8'd0) |-> (event_mask == 3'd0 && !error))
        else $error("read result shows events or error");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(read_data) && $stable(event_mask)
                                      && $stable(event_levels) && $stable(error)))
        else $error("stalled result changed");

endmodule

bind three_channel_interval_timer tcit_checker u_tcit_checker (.*);
